// File: design/lla_pkg.sv
// ----------------------------------------------------------------------------
// lla_pkg: shared types and constants for log-average luminance
// Beat types, back-end state codes and the fixed-point constants
// of the ln and exp datapaths.
// ----------------------------------------------------------------------------
package lla_pkg;

  typedef struct packed {
    logic [15:0] red_sample;
    logic [15:0] green_sample;
    logic [15:0] blue_sample;
    logic        frame_last;
  } pix_t;

  typedef struct packed {
    logic [15:0] average_luminance;
    logic        saturated;
  } res_t;

  // normalized luminance + 1: mantissa in Q1.30, exponent floor(log2 x)
  typedef struct packed {
    logic [30:0] z;
    logic [4:0]  e;
    logic        last;
  } norm_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_LNMUL,
    ST_ACC,
    ST_LAST,
    ST_DIV,
    ST_EXPMUL,
    ST_EXPCHK,
    ST_PROD,
    ST_RND,
    ST_OUT
  } state_e;

  localparam logic [15:0] WEIGHT_R  = 16'd13933;
  localparam logic [15:0] WEIGHT_G  = 16'd46871;
  localparam logic [15:0] WEIGHT_B  = 16'd4732;
  localparam logic [16:0] LN2_Q16   = 17'd45426;
  localparam logic [17:0] LOG2E_Q16 = 18'd94548;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = val;
    res = '0;
    b   = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-idx) in Q1.30, each one the truncated sqrt of the one before
  function automatic logic [31:0] exp_root(input int idx);
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int n = 1; n < idx; n++) begin
      r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

  localparam logic [31:0] EXP_ROOT [16] = '{
    exp_root(1),  exp_root(2),  exp_root(3),  exp_root(4),
    exp_root(5),  exp_root(6),  exp_root(7),  exp_root(8),
    exp_root(9),  exp_root(10), exp_root(11), exp_root(12),
    exp_root(13), exp_root(14), exp_root(15), exp_root(16)
  };

endpackage

// File: design/lla_front.sv
// ----------------------------------------------------------------------------
// lla_front: pixel intake
// Registers the Rec.709 luminance of each pixel, then normalizes it
// into mantissa and exponent on the way into the queue.
// ----------------------------------------------------------------------------
module lla_front import lla_pkg::*; #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  pix_t  pix_i,
  input  logic  push_i,
  output logic  full_o,
  output norm_t norm_o,
  output logic  norm_push_o,
  input  logic  norm_full_i
);

  localparam int SH = CHANNEL_BITS - 8;
  localparam logic [15:0] CMASK =
    (CHANNEL_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << CHANNEL_BITS) - 64'd1);

  logic        vld_q, vld_d;
  logic [26:0] x_q;
  logic        last_q;
  logic        take;
  logic [33:0] lum;
  logic [4:0]  msb;

  function automatic logic [33:0] weigh(input logic [15:0] ch, input logic [15:0] w);
    logic [31:0] p;
    logic [32:0] t;
    p = (ch & CMASK) * w;
    t = ({p, 1'b0} >> SH) + 33'd1;
    return {2'b00, t[32:1]};
  endfunction

  assign full_o      = vld_q && norm_full_i;
  assign take        = push_i && !full_o;
  assign norm_push_o = vld_q && !norm_full_i;

  always_comb begin
    lum   = weigh(pix_i.red_sample, WEIGHT_R) + weigh(pix_i.green_sample, WEIGHT_G)
          + weigh(pix_i.blue_sample, WEIGHT_B);
    vld_d = take || (vld_q && norm_full_i);
  end

  always_comb begin
    msb = '0;
    for (int n = 0; n < 27; n++) begin
      if (x_q[n]) msb = 5'(n);
    end
    norm_o.e    = msb;
    norm_o.z    = 31'({4'b0, x_q} << (5'd30 - msb));
    norm_o.last = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q    <= 27'(lum + 34'd1);
      last_q <= pix_i.frame_last;
    end
  end

endmodule

// File: design/lla_queue.sv
// ----------------------------------------------------------------------------
// lla_queue: two-entry queue between front and back
// Lets the intake keep going while the back end iterates.
// ----------------------------------------------------------------------------
module lla_queue import lla_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  norm_t wdata_i,
  input  logic  wr_i,
  output logic  full_o,
  output norm_t rdata_o,
  input  logic  rd_i,
  output logic  empty_o
);

  norm_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) wp_q <= !wp_q;
      if (rd_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

endmodule

// File: design/lla_back.sv
// ----------------------------------------------------------------------------
// lla_back: ln, accumulate, divide and exp sequencer
// One multiplier step per cycle for the ln squaring chain and another for the
// exp product chain, and a bit-serial divider for the frame mean.
// ----------------------------------------------------------------------------
module lla_back import lla_pkg::*; #(
  parameter int MAX_PIXELS_LOG2 = 22
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  norm_t norm_i,
  input  logic  norm_empty_i,
  output logic  norm_pop_o,
  output res_t  res_o,
  output logic  empty_o,
  input  logic  pop_i
);

  localparam int CW = MAX_PIXELS_LOG2 + 1;
  localparam int RW = MAX_PIXELS_LOG2 + 2;

  state_e state_q, state_d;

  logic [30:0]        z_q;
  logic [4:0]         e_q;
  logic               last_q;
  logic [15:0]        frac_q;
  logic [5:0]         it_q;
  logic signed [38:0] lnp_q;
  logic signed [47:0] sum_q;
  logic [CW-1:0]      cnt_q;
  logic               clip_q;
  logic [RW-1:0]      rem_q;
  logic [48:0]        quo_q;
  logic               neg_q;
  logic signed [24:0] y_q;
  logic [30:0]        p_q;
  logic [15:0]        avg_q;
  logic               sat_q;
  logic               ovld_q;
  res_t               out_q;

  logic [61:0]        sq;
  logic [31:0]        zn;
  logic signed [21:0] lg;
  logic [47:0]        mag;
  logic [RW-1:0]      rs;
  logic signed [22:0] mean;
  logic signed [40:0] ym;
  logic signed [8:0]  k;
  logic [62:0]        pr;
  logic signed [9:0]  sh;
  logic [32:0]        rnd;

  always_comb begin
    sq   = 62'(z_q) * 62'(z_q);
    zn   = sq[61:30];
    lg   = $signed({6'({1'b0, e_q} - 6'd16), frac_q});
    mag  = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
    rs   = {rem_q[RW-2:0], quo_q[48]};
    mean = neg_q ? -$signed({1'b0, quo_q[21:0]}) : $signed({1'b0, quo_q[21:0]});
    ym   = 41'(mean) * $signed({23'b0, LOG2E_Q16});
    k    = y_q[24:16];
    pr   = 63'(p_q) * 63'(EXP_ROOT[it_q[3:0]]);
    sh   = 10'sd22 - 10'(k);
    rnd  = ({2'b00, p_q} + (33'd1 << 5'(sh - 10'sd1))) >> 5'(sh);
  end

  always_comb begin
    state_d    = state_q;
    norm_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!norm_empty_i) begin
          norm_pop_o = 1'b1;
          if (cnt_q[MAX_PIXELS_LOG2]) begin
            state_d = norm_i.last ? ST_LAST : ST_IDLE;
          end else begin
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ:     if (it_q == 6'd15) state_d = ST_LNMUL;
      ST_LNMUL:  state_d = ST_ACC;
      ST_ACC:    state_d = last_q ? ST_LAST : ST_IDLE;
      ST_LAST:   state_d = (cnt_q == '0) ? ST_EXPMUL : ST_DIV;
      ST_DIV:    if (it_q == 6'd48) state_d = ST_EXPMUL;
      ST_EXPMUL: state_d = ST_EXPCHK;
      ST_EXPCHK: state_d = (k >= 9'sd8) ? ST_OUT : ST_PROD;
      ST_PROD:   if (it_q == 6'd15) state_d = ST_RND;
      ST_RND:    state_d = ST_OUT;
      ST_OUT:    if (!ovld_q) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q   <= '0;
      cnt_q   <= '0;
      clip_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_i && ovld_q) ovld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (!norm_empty_i && cnt_q[MAX_PIXELS_LOG2]) clip_q <= 1'b1;
        end
        ST_ACC: begin
          sum_q <= sum_q + 48'(signed'(lnp_q[38:16]));
          cnt_q <= cnt_q + CW'(1);
        end
        ST_OUT: begin
          if (!ovld_q) begin
            ovld_q <= 1'b1;
            sum_q  <= '0;
            cnt_q  <= '0;
            clip_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        z_q    <= norm_i.z;
        e_q    <= norm_i.e;
        last_q <= norm_i.last;
        frac_q <= '0;
        it_q   <= '0;
      end
      ST_SQ: begin
        if (zn[31]) begin
          z_q    <= zn[31:1];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          z_q    <= zn[30:0];
          frac_q <= {frac_q[14:0], 1'b0};
        end
        it_q <= it_q + 6'd1;
      end
      ST_LNMUL: begin
        lnp_q <= 39'(lg) * $signed({22'b0, LN2_Q16}) + 39'sd32768;
      end
      ST_LAST: begin
        quo_q <= {1'b0, mag} + 49'(cnt_q >> 1);
        rem_q <= '0;
        neg_q <= sum_q[47];
        it_q  <= '0;
        sat_q <= 1'b0;
        if (cnt_q == '0) begin
          quo_q <= '0;
          neg_q <= 1'b0;
        end
      end
      ST_DIV: begin
        if (rs >= RW'(cnt_q)) begin
          rem_q <= rs - RW'(cnt_q);
          quo_q <= {quo_q[47:0], 1'b1};
        end else begin
          rem_q <= rs;
          quo_q <= {quo_q[47:0], 1'b0};
        end
        it_q <= it_q + 6'd1;
      end
      ST_EXPMUL: y_q <= 25'(ym >>> 16);
      ST_EXPCHK: begin
        p_q  <= 31'd1 << 30;
        it_q <= '0;
        if (k >= 9'sd8) begin
          avg_q <= 16'hFFFF;
          sat_q <= 1'b1;
        end
      end
      ST_PROD: begin
        if (y_q[4'd15 - it_q[3:0]]) p_q <= pr[60:30];
        it_q <= it_q + 6'd1;
      end
      ST_RND: begin
        if (sh >= 10'sd32) begin
          avg_q <= '0;
        end else if (rnd > 33'd65535) begin
          avg_q <= 16'hFFFF;
          sat_q <= 1'b1;
        end else begin
          avg_q <= rnd[15:0];
        end
      end
      ST_OUT: begin
        if (!ovld_q) begin
          out_q.average_luminance <= avg_q;
          out_q.saturated         <= sat_q || clip_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o   = out_q;
  assign empty_o = !ovld_q;

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0))
    else $error("divide with zero pixel count");
  a_sq_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |-> z_q[30])
    else $error("ln mantissa not normalized");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !ovld_q) |=> (ovld_q && state_q == ST_IDLE && cnt_q == '0))
    else $error("result beat not loaded");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[MAX_PIXELS_LOG2]) |-> (cnt_q[MAX_PIXELS_LOG2-1:0] == '0))
    else $error("pixel count beyond cap");
`endif

endmodule

// File: design/log_average_luminance.sv
// Flow: a pixel is registered in the front and then held in the queue; the back
// runs 16 ln squaring steps on one 31x31 multiplier, the ln2 scale and the add
// for each pixel. The frame's last pixel then adds a 49-step serial divide, exp
// scale, 16 exp product steps and rounding, before the result beat.
// The back takes no pixel before the last is done; ln squaring sets the pace.
// Reset clears the accumulators, count, queue and result-valid flag at once.
// ----------------------------------------------------------------------------
// log_average_luminance: geometric-mean luminance of a pixel stream
// Front computes luminance, a short queue decouples it from the back,
// which accumulates ln and emits exp(mean) per frame.
// ----------------------------------------------------------------------------
module log_average_luminance import lla_pkg::*; #(
  parameter int MAX_PIXELS_LOG2 = 22,
  parameter int CHANNEL_BITS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  pix_t pix_i,
  input  logic push,
  output logic full,
  output res_t res_o,
  output logic empty,
  input  logic pop
);

  norm_t f_norm, q_norm;
  logic  f_push, q_full, q_empty, b_pop;

  lla_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .push_i      (push),
    .full_o      (full),
    .norm_o      (f_norm),
    .norm_push_o (f_push),
    .norm_full_i (q_full)
  );

  lla_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wdata_i (f_norm),
    .wr_i    (f_push),
    .full_o  (q_full),
    .rdata_o (q_norm),
    .rd_i    (b_pop),
    .empty_o (q_empty)
  );

  lla_back #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .norm_i       (q_norm),
    .norm_empty_i (q_empty),
    .norm_pop_o   (b_pop),
    .res_o        (res_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

// File: sim/lla_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_checker: scoreboard for log-average luminance
// Watches pixel and result beats, predicts the geometric-mean luminance of
// each frame and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module lla_checker import lla_pkg::*; #(
  parameter int MAX_PIXELS_LOG2 = 22,
  parameter int CHANNEL_BITS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  pix_t pix_i,
  input  logic push,
  input  logic full,
  input  res_t res_o,
  input  logic empty,
  input  logic pop,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   frames_o,
  output int   sat_cnt_o
);

  res_t            frame_avg_q[$];
  logic signed [63:0] ln_acc;
  logic [31:0]     pix_cnt;
  logic            cnt_clip;

  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] v, acc, b;
    v   = val;
    acc = '0;
    b   = 64'd1 << 62;
    while (b > v && b != 0) b = b >> 2;
    while (b != 0) begin
      if (v >= acc + b) begin
        v   = v - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc;
  endfunction

  function automatic logic [63:0] chan_term(input logic [15:0] ch, input logic [15:0] w);
    logic [63:0] p;
    p = {48'd0, ch} * {48'd0, w};
    return (((p << 1) >> (CHANNEL_BITS - 8)) + 64'd1) >> 1;
  endfunction

  function automatic logic signed [63:0] pixel_ln(input logic [63:0] x);
    int unsigned        e;
    logic [63:0]        z;
    logic signed [63:0] frac, lg;
    e    = 0;
    frac = 0;
    while (e < 40 && (x >> (e + 1)) != 0) e++;
    z = x << (30 - e);
    for (int i = 0; i < 16; i++) begin
      z    = (z * z) >> 30;
      frac = frac << 1;
      if (z >= (64'd1 << 31)) begin
        z    = z >> 1;
        frac = frac | 1;
      end
    end
    lg = (64'(signed'(e)) - 16) * 65536 + frac;
    return (lg * 64'(signed'({1'b0, LN2_Q16})) + 32768) >>> 16;
  endfunction

  function automatic res_t mean_to_lum(input logic signed [63:0] mean);
    logic signed [63:0] y, k, f;
    logic [63:0]        p, r, rnd;
    int unsigned        sh;
    res_t               o;
    o = '0;
    y = (mean * 64'(signed'({1'b0, LOG2E_Q16}))) >>> 16;
    k = y >>> 16;
    f = y - k * 65536;
    if (k >= 8) begin
      o.average_luminance = 16'hFFFF;
      o.saturated         = 1'b1;
      return o;
    end
    p = 64'd1 << 30;
    r = int_sqrt(64'd1 << 61);
    for (int i = 1; i <= 16; i++) begin
      if ((f >> (16 - i)) & 1) p = (p * r) >> 30;
      r = int_sqrt(r << 30);
    end
    if (22 - k > 62) return o;
    sh  = 22 - k;
    rnd = (p + (64'd1 << (sh - 1))) >> sh;
    if (rnd > 65535) begin
      o.average_luminance = 16'hFFFF;
      o.saturated         = 1'b1;
    end else begin
      o.average_luminance = rnd[15:0];
    end
    return o;
  endfunction

  assign pending_o = frame_avg_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0]        cmask, lum, mag, q;
    logic signed [63:0] mean;
    res_t               exp_r, got;
    if (!rst_ni) begin
      ln_acc      = 0;
      pix_cnt     = 0;
      cnt_clip    = 0;
      fail_cnt_o <= 0;
      frames_o   <= 0;
      sat_cnt_o  <= 0;
      frame_avg_q.delete();
    end else begin
      if (pop && !empty) begin
        got = res_o;
        if (frame_avg_q.size() == 0) begin
          $display("%0t: unexpected result beat avg=%h sat=%b", $time,
                   got.average_luminance, got.saturated);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_r = frame_avg_q.pop_front();
          if (got.average_luminance !== exp_r.average_luminance ||
              got.saturated !== exp_r.saturated) begin
            $display("%0t: mismatch exp avg=%h sat=%b got avg=%h sat=%b", $time,
                     exp_r.average_luminance, exp_r.saturated,
                     got.average_luminance, got.saturated);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (push && !full) begin
        cmask = (64'd1 << CHANNEL_BITS) - 1;
        if (pix_cnt >= (32'd1 << MAX_PIXELS_LOG2)) begin
          cnt_clip = 1'b1;
        end else begin
          lum = chan_term(pix_i.red_sample & cmask, WEIGHT_R) +
                chan_term(pix_i.green_sample & cmask, WEIGHT_G) +
                chan_term(pix_i.blue_sample & cmask, WEIGHT_B);
          ln_acc  = ln_acc + pixel_ln(lum + 1);
          pix_cnt = pix_cnt + 1;
        end
        if (pix_i.frame_last) begin
          mean = 0;
          if (pix_cnt != 0) begin
            mag  = ln_acc < 0 ? 64'(-ln_acc) : 64'(ln_acc);
            q    = (mag + pix_cnt / 2) / pix_cnt;
            mean = ln_acc < 0 ? -64'(signed'(q)) : 64'(signed'(q));
          end
          exp_r = mean_to_lum(mean);
          exp_r.saturated = exp_r.saturated | cnt_clip;
          if (exp_r.saturated) sat_cnt_o <= sat_cnt_o + 1;
          frame_avg_q.push_back(exp_r);
          frames_o <= frames_o + 1;
          ln_acc   = 0;
          pix_cnt  = 0;
          cnt_clip = 0;
        end
      end
    end
  end

endmodule

// File: sim/tb_log_average_luminance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_average_luminance: testbench for log-average luminance
// Drives frames of RGB pixels with random gaps and result stalls, including
// one long receiver hold-off; a checker predicts each frame's result.
// ----------------------------------------------------------------------------
module tb_log_average_luminance;
  import lla_pkg::*;

  localparam int WDOG_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  pix_t pix_i = '0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  res_t res_o;
  int   fail_cnt, pending, frames, sat_cnt;
  int   pix_sent = 0;
  int   idle_cycles = 0;
  bit   rx_hold_req = 0;

  always #5 clk_i = ~clk_i;

  log_average_luminance u_dut (
    .clk_i, .rst_ni, .pix_i, .push, .full, .res_o, .empty, .pop
  );

  lla_checker u_chk (
    .clk_i, .rst_ni, .pix_i, .push, .full, .res_o, .empty, .pop,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .frames_o(frames),
    .sat_cnt_o(sat_cnt)
  );

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom) >> $urandom_range(0, 15);
      2: return 16'hFFFF - (16'($urandom) >> $urandom_range(4, 15));
      default: return 16'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_pix(input logic [15:0] r, g, b, input logic last, input bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    pix_i <= '{red_sample: r, green_sample: g, blue_sample: b, frame_last: last};
    push  <= 1'b1;
    do @(posedge clk_i); while (full);
    pix_sent++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 0;
        pop <= 1'b0;
        repeat (1500) @(posedge clk_i);
      end
      n = gap_len();
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("[log_average_luminance] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int len, w;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and single-bit channels, then short frames back to back
    send_pix(16'h0000, 16'h0000, 16'h0000, 1'b1, 0);
    send_pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0);
    send_pix(16'hFFFF, 16'h0000, 16'h0000, 1'b1, 0);
    send_pix(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 0);
    send_pix(16'h0000, 16'h0000, 16'hFFFF, 1'b1, 0);
    send_pix(16'h0100, 16'h0100, 16'h0100, 1'b1, 0);
    send_pix(16'h0001, 16'h0001, 16'h0001, 1'b1, 0);
    for (int i = 0; i < 16; i += 3)
      send_pix(16'd1 << i, 16'd1 << ((i + 5) % 16), 16'd1 << ((i + 11) % 16), i >= 15, 0);
    send_pix(16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
    send_pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0);
    send_pix(16'h8000, 16'h7FFF, 16'h5555, 1'b0, 0);
    send_pix(16'hAAAA, 16'h0080, 16'h3C3C, 1'b1, 0);

    // random frames; the receiver holds off early so the block backs up
    rx_hold_req = 1;
    while (pix_sent < 1540) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      w   = $urandom_range(0, 3);
      for (int p = 0; p < len; p++) begin
        if (w == 0)
          send_pix(16'hFF00 | 16'($urandom_range(0, 255)), 16'hFFFF - 16'($urandom_range(0, 4095)),
                   rand_chan(), p == len - 1, 1);
        else if (w == 1)
          send_pix(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                   16'($urandom_range(0, 7)), p == len - 1, 1);
        else
          send_pix(rand_chan(), rand_chan(), rand_chan(), p == len - 1, 1);
      end
    end
    push <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("sent %0d pixels in %0d frames, %0d saturated results", pix_sent, frames, sat_cnt);
    $display("included extremes, single-bit channels and a long result hold-off");
    if (fail_cnt == 0) begin
      $display("[log_average_luminance] OK");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("[log_average_luminance] ERROR");
    end
    $finish;
  end

endmodule
